// File: sv/alte_pkg.sv
// shared types and constants for the array list table engine
// no dependencies
package alte_pkg;

    localparam int DATA_W       = 32;
    localparam int IDX_W        = 6;
    localparam int CNT_OUT_W    = 7;
    localparam int MAX_CAPACITY = 1024;
    localparam int BUS_W        = $clog2(MAX_CAPACITY + 1);
    localparam int DEF_CAPACITY = 64;

    typedef enum logic [1:0] {
        REQ_SEARCH  = 2'd0,
        REQ_REPLACE = 2'd1,
        REQ_APPEND  = 2'd2,
        REQ_REMOVE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_RANGE     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic              fire;
        t_req              op;
        logic [BUS_W-1:0]  idx;
        logic [BUS_W-1:0]  cnt;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

// File: sv/alte_cell.sv
// one table slot: holds an entry, compares it with the search key and
// takes its upper neighbor's entry on a remove; depends on alte_pkg
module alte_cell
    import alte_pkg::*;
#(
    parameter int POS = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_cmd         i_cmd,
    input  logic [DATA_W-1:0] i_nbr,
    input  logic [DATA_W-1:0] i_key,
    output logic [DATA_W-1:0] o_q,
    output logic              o_match,
    output logic [DATA_W-1:0] o_rd
);

    localparam logic [BUS_W-1:0] POS_B = BUS_W'(POS);

    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_cmd.fire) begin
            case (i_cmd.op)
                REQ_REPLACE: if (POS_B == i_cmd.idx) n_q = i_cmd.value;
                REQ_APPEND:  if (POS_B == i_cmd.cnt) n_q = i_cmd.value;
                // every slot at or above the removed one moves down
                REQ_REMOVE:  if (POS_B >= i_cmd.idx) n_q = i_nbr;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q     = r_q;
    assign o_match = (r_q == i_key);
    assign o_rd    = (POS_B == i_cmd.idx) ? r_q : '0;

endmodule

// File: sv/alte_find.sv
// registered priority tree that finds the lowest set match bit
// one register level per tree level; depends on alte_pkg
module alte_find
    import alte_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                        i_clk,
    input  logic [CAPACITY-1:0]         i_match,
    output logic                        o_hit,
    output logic [$clog2(CAPACITY)-1:0] o_pos
);

    localparam int LVLS = $clog2(CAPACITY);
    localparam int NL   = 2 ** LVLS;
    localparam int NN   = 2 * NL - 1;

    // heap layout: node k has children 2k+1 and 2k+2, leaves from NL-1
    logic [NN-1:0]   r_hit;
    logic [LVLS-1:0] nd_pos [NN];
    logic [LVLS-1:0] r_pos  [NL-1];

    genvar k;
    generate
        for (k = 0; k < NL; k++) begin : g_leaf
            assign nd_pos[NL-1+k] = LVLS'(k);
            if (k < CAPACITY) begin : g_real
                always_ff @(posedge i_clk) begin
                    r_hit[NL-1+k] <= i_match[k];
                end
            end else begin : g_pad
                always_ff @(posedge i_clk) begin
                    r_hit[NL-1+k] <= 1'b0;
                end
            end
        end
        for (k = 0; k < NL - 1; k++) begin : g_node
            assign nd_pos[k] = r_pos[k];
            always_ff @(posedge i_clk) begin
                r_hit[k] <= r_hit[2*k+1] | r_hit[2*k+2];
                r_pos[k] <= r_hit[2*k+1] ? nd_pos[2*k+1] : nd_pos[2*k+2];
            end
        end
    endgenerate

    assign o_hit = r_hit[0];
    assign o_pos = nd_pos[0];

endmodule

// File: sv/array_list_table_engine.sv
// array list table engine: row of cells with search, replace, append, remove
// replace, append and remove: result is registered when the item is taken and shows in the next cycle
// search: CAPACITY cells compare at once, then a registered priority tree of
//   log2(CAPACITY) levels picks the lowest matching slot
// throughput: replace, append, remove one item per cycle while results are taken; no new item during a search
// synchronous reset clears every slot and the count
module array_list_table_engine
    import alte_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_req_type,
    input  logic [IDX_W-1:0]     i_slot_index,
    input  logic [DATA_W-1:0]    i_data_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [IDX_W-1:0]     o_found_index,
    output logic [DATA_W-1:0]    o_old_value,
    output logic [CNT_OUT_W-1:0] o_element_count
);

    localparam int LVLS = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SW   = $clog2(LVLS + 2);
    localparam logic [BUS_W-1:0] CAP_B   = BUS_W'(CAPACITY);
    localparam logic [SW-1:0]    SRCH_END = SW'(LVLS + 1);

    typedef enum logic {S_IDLE, S_SRCH} t_state;

    t_state             r_state;
    logic [SW-1:0]      r_cnt;
    logic [CW-1:0]      r_count;
    logic [DATA_W-1:0]  r_key;
    logic               r_out_valid;
    t_status            r_status;
    logic [IDX_W-1:0]   r_found;
    logic [DATA_W-1:0]  r_old;

    t_state             n_state;
    logic [SW-1:0]      n_cnt;
    logic [CW-1:0]      n_count;
    logic [DATA_W-1:0]  n_key;
    logic               n_out_valid;
    t_status            n_status;
    logic [IDX_W-1:0]   n_found;
    logic [DATA_W-1:0]  n_old;

    logic               in_fire;
    t_req               req;
    logic [BUS_W-1:0]   idx_b;
    logic               idx_ok;
    t_cell_cmd          cmd;
    logic [DATA_W-1:0]  cell_q  [CAPACITY];
    logic [DATA_W-1:0]  cell_rd [CAPACITY];
    logic [DATA_W-1:0]  cell_nbr [CAPACITY];
    logic [CAPACITY-1:0] match;
    logic [DATA_W-1:0]  old_sel;
    logic               root_hit;
    logic [LVLS-1:0]    root_pos;
    logic [LVLS+IDX_W-1:0]   pos_ext;
    logic [CW+CNT_OUT_W-1:0] count_ext;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;
    assign req        = t_req'(i_req_type);
    assign idx_b      = {{(BUS_W-IDX_W){1'b0}}, i_slot_index};
    assign idx_ok     = idx_b < CAP_B;

    always_comb begin
        cmd.fire  = in_fire;
        cmd.op    = req;
        cmd.idx   = idx_b;
        cmd.cnt   = BUS_W'(r_count);
        cmd.value = i_data_value;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == CAPACITY - 1) begin : g_last
                assign cell_nbr[g] = '0;
            end else begin : g_mid
                assign cell_nbr[g] = cell_q[g+1];
            end
            alte_cell #(
                .POS (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (cmd),
                .i_nbr   (cell_nbr[g]),
                .i_key   (r_key),
                .o_q     (cell_q[g]),
                .o_match (match[g]),
                .o_rd    (cell_rd[g])
            );
        end
    endgenerate

    alte_find #(
        .CAPACITY (CAPACITY)
    ) u_find (
        .i_clk   (i_clk),
        .i_match (match),
        .o_hit   (root_hit),
        .o_pos   (root_pos)
    );

    // at most one cell drives a nonzero read
    always_comb begin
        old_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            old_sel = old_sel | cell_rd[i];
        end
    end

    assign pos_ext   = {{IDX_W{1'b0}}, root_pos};
    assign count_ext = {{CNT_OUT_W{1'b0}}, r_count};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_count     = r_count;
        n_key       = r_key;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_found     = r_found;
        n_old       = r_old;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_found = '0;
                    n_old   = '0;
                    n_status = ST_OK;
                    unique case (req)
                        REQ_SEARCH: begin
                            n_key   = i_data_value;
                            n_cnt   = '0;
                            n_state = S_SRCH;
                        end
                        REQ_REPLACE: begin
                            n_out_valid = 1'b1;
                            if (idx_ok) begin
                                n_old = old_sel;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        REQ_APPEND: begin
                            n_out_valid = 1'b1;
                            if (BUS_W'(r_count) < CAP_B) begin
                                n_count = r_count + 1'b1;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        REQ_REMOVE: begin
                            n_out_valid = 1'b1;
                            if (!idx_ok) begin
                                n_status = ST_RANGE;
                            end else if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SRCH: begin
                n_cnt = r_cnt + 1'b1;
                // tree root holds the answer once leaves and all levels settled
                if (r_cnt == SRCH_END) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (root_hit) begin
                        n_status = ST_OK;
                        n_found  = pos_ext[IDX_W-1:0];
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_found  = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_key    <= n_key;
        r_status <= n_status;
        r_found  <= n_found;
        r_old    <= n_old;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_found_index   = r_found;
    assign o_old_value     = r_old;
    assign o_element_count = count_ext[CNT_OUT_W-1:0];

endmodule

// File: verif/array_list_table_engine_tb.sv
// testbench for array_list_table_engine: directed and random table requests
// checked field by field against an in-bench model of the table and its count
// depends on alte_pkg and the array_list_table_engine rtl
module array_list_table_engine_tb
    import alte_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        t_status                status;
        logic [IDX_W-1:0]       found_index;
        logic [DATA_W-1:0]      old_value;
        logic [CNT_OUT_W-1:0]   element_count;
    } t_table_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_req_type = REQ_SEARCH;
    logic [IDX_W-1:0]     i_slot_index = '0;
    logic [DATA_W-1:0]    i_data_value = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [1:0]           o_status;
    logic [IDX_W-1:0]     o_found_index;
    logic [DATA_W-1:0]    o_old_value;
    logic [CNT_OUT_W-1:0] o_element_count;

    logic [DATA_W-1:0] model_entries [CAPACITY];
    int unsigned       model_count;
    t_table_result     expected_results [$];
    int                mismatches = 0;
    bit                steady_flow = 1'b0;

    array_list_table_engine #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_slot_index   (i_slot_index),
        .i_data_value   (i_data_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_found_index  (o_found_index),
        .o_old_value    (o_old_value),
        .o_element_count(o_element_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // applies one request to the table model and returns the result it gives
    function automatic t_table_result predict_table_request(t_req op, logic [IDX_W-1:0] idx,
                                                            logic [DATA_W-1:0] val);
        t_table_result res;
        bit            hit;
        int            i;
        res = '0;
        res.status = ST_OK;
        case (op)
            REQ_SEARCH: begin
                hit = 1'b0;
                // whole table is scanned, slots past the count included
                for (i = 0; i < CAPACITY; i++) begin
                    if (!hit && model_entries[i] == val) begin
                        hit = 1'b1;
                        res.found_index = IDX_W'(i);
                    end
                end
                if (!hit) res.status = ST_NOT_FOUND;
            end
            REQ_REPLACE: begin
                if (idx < CAPACITY) begin
                    res.old_value = model_entries[idx];
                    model_entries[idx] = val;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            REQ_APPEND: begin
                if (model_count < CAPACITY) begin
                    model_entries[model_count] = val;
                    model_count++;
                end else begin
                    res.status = ST_FULL;
                end
            end
            default: begin
                if (idx < CAPACITY) begin
                    for (i = idx; i + 1 < CAPACITY; i++) model_entries[i] = model_entries[i + 1];
                    model_entries[CAPACITY - 1] = '0;
                    if (model_count > 0) model_count--;
                end else begin
                    res.status = ST_RANGE;
                end
            end
        endcase
        res.element_count = CNT_OUT_W'(model_count);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // favors values already in the table so that searches hit often
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return model_entries[$urandom_range(0, CAPACITY - 1)];
        if (r < 60) return DATA_W'($urandom_range(0, 15));
        if (r < 68) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom();
    endfunction

    task automatic send_request(t_req op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= op;
        i_slot_index <= idx;
        i_data_value <= val;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        expected_results.push_back(predict_table_request(op, idx, val));
    endtask

    task automatic report_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s at %0t: got %h, want %h", field, $realtime, got, want);
    endtask

    initial begin : result_sink
        int stall;
        forever begin
            stall = pick_gap();
            if (stall > 0 && $urandom_range(0, 1) == 1) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_table_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", '0, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", DATA_W'(o_status), DATA_W'(want.status));
                if (o_found_index !== want.found_index)
                    report_mismatch("found_index", DATA_W'(o_found_index),
                                    DATA_W'(want.found_index));
                if (o_old_value !== want.old_value)
                    report_mismatch("old_value", o_old_value, want.old_value);
                if (o_element_count !== want.element_count)
                    report_mismatch("element_count", DATA_W'(o_element_count),
                                    DATA_W'(want.element_count));
            end
        end
    end

    // extremes, every operation, and the corner behaviors of the table
    task automatic test_directed();
        send_request(REQ_SEARCH,  6'd0,  32'h0000_0000);   // empty table still holds zeros
        send_request(REQ_SEARCH,  6'd0,  32'h7FFF_FFFF);   // miss
        send_request(REQ_REMOVE,  6'd0,  32'h0000_0000);   // remove on empty, count stays zero
        send_request(REQ_REPLACE, 6'd63, 32'h8000_0000);   // replace past the count
        send_request(REQ_SEARCH,  6'd0,  32'h8000_0000);   // found in unused slot
        send_request(REQ_REPLACE, 6'd63, 32'h7FFF_FFFF);
        send_request(REQ_APPEND,  6'd63, 32'h7FFF_FFFF);
        send_request(REQ_APPEND,  6'd0,  32'h8000_0000);
        send_request(REQ_APPEND,  6'd21, 32'hFFFF_FFFF);
        send_request(REQ_SEARCH,  6'd42, 32'hFFFF_FFFF);
        send_request(REQ_SEARCH,  6'd0,  32'h7FFF_FFFF);   // lowest of two matches
        send_request(REQ_REMOVE,  6'd0,  32'h0000_0000);   // shift everything down
        send_request(REQ_SEARCH,  6'd0,  32'h7FFF_FFFF);
        send_request(REQ_REPLACE, 6'd0,  32'h5555_5555);
        send_request(REQ_REPLACE, 6'd1,  32'hAAAA_AAAA);
        send_request(REQ_SEARCH,  6'd0,  32'hAAAA_AAAA);
        send_request(REQ_REMOVE,  6'd63, 32'h0000_0000);   // last slot
        send_request(REQ_REMOVE,  6'd2,  32'hFFFF_FFFF);
        send_request(REQ_REMOVE,  6'd5,  32'h0000_0000);
        send_request(REQ_REMOVE,  6'd0,  32'h0000_0000);   // count saturates at zero
        send_request(REQ_SEARCH,  6'd0,  32'h5555_5555);
    endtask

    // append up to capacity, then a few appends against the full table
    task automatic test_fill_to_capacity();
        while (model_count < CAPACITY) begin
            if ($urandom_range(0, 7) == 0)
                send_request(REQ_SEARCH, IDX_W'($urandom()), pick_value());
            else
                send_request(REQ_APPEND, IDX_W'($urandom()), pick_value());
        end
        repeat (4) send_request(REQ_APPEND, IDX_W'($urandom()), $urandom());
    endtask

    task automatic test_random_mix(int n_items);
        int r;
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            if (r < 30)
                send_request(REQ_SEARCH, IDX_W'($urandom()), pick_value());
            else if (r < 55)
                send_request(REQ_REPLACE, IDX_W'($urandom()), pick_value());
            else if (r < 80)
                send_request(REQ_APPEND, IDX_W'($urandom()), pick_value());
            else
                send_request(REQ_REMOVE, IDX_W'($urandom()), pick_value());
        end
    endtask

    // remove until empty, then a few removes on the empty table
    task automatic test_drain();
        while (model_count > 0) begin
            if ($urandom_range(0, 5) == 0)
                send_request(REQ_SEARCH, IDX_W'($urandom()), pick_value());
            else
                send_request(REQ_REMOVE, IDX_W'($urandom_range(0, model_count - 1)), $urandom());
        end
        repeat (3) send_request(REQ_REMOVE, IDX_W'($urandom()), $urandom());
    endtask

    initial begin : limit_guard
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : run_tests
        int pass_num;
        foreach (model_entries[i]) model_entries[i] = '0;
        model_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        for (pass_num = 0; pass_num < 4; pass_num++) begin
            steady_flow = (pass_num == 1);
            test_fill_to_capacity();
            test_random_mix(320);
            test_drain();
        end
        steady_flow = 1'b0;
        i_in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
